### design/ple_pkg.sv
// shared types and constants for the positional list engine
// no dependencies; imported by ple_ctrl and the top level
`default_nettype none

package ple_pkg;

  localparam int ACTION_W       = 3;
  localparam int POS_W          = 7;
  localparam int IN_DATA_W      = 32;
  localparam int COUNT_OUT_W    = 7;
  localparam int S_TDATA_W      = 40;
  localparam int S_TUSER_W      = 3;
  localparam int M_TDATA_W      = 48;
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_READ    = 3'd1,
    ACT_REMOVE  = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_REVERSE = 3'd4
  } action_e;

  typedef struct packed {
    logic success;
    logic empty;
  } res_flags_t;

endpackage

`default_nettype wire

### design/ple_ram.sv
// single-port-write, single-port-read node memory with registered read data
// depends on nothing but its parameters
`default_nettype none

module ple_ram #(
  parameter  int DEPTH = 64,
  parameter  int WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/ple_ctrl.sv
// list sequencer: decodes one transaction, walks and rewrites the node links,
// keeps head, count, free list and fill mark; uses ple_pkg
`default_nettype none

module ple_ctrl #(
  parameter  int CAPACITY   = ple_pkg::DEF_CAPACITY,
  parameter  int DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH,
  localparam int AW         = $clog2(CAPACITY),
  localparam int CW         = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire ple_pkg::action_e              action_i,
  input  wire logic [ple_pkg::POS_W-1:0]     position_i,
  input  wire logic [DATA_WIDTH-1:0]         data_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output ple_pkg::res_flags_t                res_flags_o,
  output logic      [DATA_WIDTH-1:0]         res_data_o,
  output logic      [CW-1:0]                 res_count_o,
  output logic                               ent_we_o,
  output logic      [AW-1:0]                 ent_waddr_o,
  output logic      [DATA_WIDTH-1:0]         ent_wdata_o,
  output logic                               ent_re_o,
  output logic      [AW-1:0]                 ent_raddr_o,
  input  wire logic [DATA_WIDTH-1:0]         ent_rdata_i,
  output logic                               lnk_we_o,
  output logic      [AW-1:0]                 lnk_waddr_o,
  output logic      [AW-1:0]                 lnk_wdata_o,
  output logic                               lnk_re_o,
  output logic      [AW-1:0]                 lnk_raddr_o,
  input  wire logic [AW-1:0]                 lnk_rdata_i
);

  import ple_pkg::*;

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_INS,
    S_WALK,
    S_OP,
    S_OP2,
    S_REV
  } state_e;

  state_e                state_q, state_d;
  logic                  fin_q, fin_d;
  action_e               act_q, act_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [DATA_WIDTH-1:0] din_q, din_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         hwm_q, hwm_d;
  logic [AW-1:0]         head_q, head_d;
  logic [AW-1:0]         fhead_q, fhead_d;
  logic [AW-1:0]         fresh_q, fresh_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [AW-1:0]         prev_q, prev_d;
  logic [AW-1:0]         succ_q, succ_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         tgt_q, tgt_d;
  logic                  ok_q, ok_d;
  logic [DATA_WIDTH-1:0] rdata_q, rdata_d;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] cnt_ext;
  logic          ins_ok;
  logic          rd_ok;

  assign pos_ext = PW'(pos_q);
  assign pos_m1  = pos_ext - PW'(1);
  assign cnt_ext = PW'(count_q);
  assign ins_ok  = (pos_ext <= cnt_ext) && (count_q != CW'(CAPACITY));
  assign rd_ok   = (pos_ext < cnt_ext);

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    act_d       = act_q;
    pos_d       = pos_q;
    din_d       = din_q;
    count_d     = count_q;
    hwm_d       = hwm_q;
    head_d      = head_q;
    fhead_d     = fhead_q;
    fresh_d     = fresh_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    succ_d      = succ_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    ok_d        = ok_q;
    rdata_d     = rdata_q;
    ent_we_o    = 1'b0;
    ent_waddr_o = fresh_q;
    ent_wdata_o = din_q;
    ent_re_o    = 1'b0;
    ent_raddr_o = cur_q;
    lnk_we_o    = 1'b0;
    lnk_waddr_o = cur_q;
    lnk_wdata_o = prev_q;
    lnk_re_o    = 1'b0;
    lnk_raddr_o = cur_q;

    if (fin_q) begin
      if (res_ready_i) begin
        fin_d = 1'b0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_d   = action_i;
            pos_d   = position_i;
            din_d   = data_i;
            state_d = S_DECODE;
          end
        end
        S_DECODE: begin
          ok_d    = 1'b0;
          rdata_d = '0;
          state_d = S_IDLE;
          fin_d   = 1'b1;
          unique case (act_q)
            ACT_INSERT: begin
              if (ins_ok) begin
                fin_d = 1'b0;
                if (hwm_q != count_q) begin
                  // reuse a freed node
                  fresh_d     = fhead_q;
                  lnk_re_o    = 1'b1;
                  lnk_raddr_o = fhead_q;
                  state_d     = S_POP;
                end else begin
                  fresh_d = hwm_q[AW-1:0];
                  hwm_d   = hwm_q + CW'(1);
                  state_d = S_INS;
                end
              end
            end
            ACT_READ, ACT_REMOVE: begin
              if (rd_ok) begin
                fin_d       = 1'b0;
                lnk_re_o    = 1'b1;
                lnk_raddr_o = head_q;
                cur_d       = head_q;
                idx_d       = '0;
                tgt_d       = pos_ext[CW-1:0];
                state_d     = S_WALK;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
              head_d  = '0;
              hwm_d   = '0;
              ok_d    = 1'b1;
            end
            ACT_REVERSE: begin
              ok_d = 1'b1;
              if (count_q > CW'(1)) begin
                fin_d       = 1'b0;
                lnk_re_o    = 1'b1;
                lnk_raddr_o = head_q;
                cur_d       = head_q;
                idx_d       = '0;
                state_d     = S_REV;
              end
            end
            default: begin
            end
          endcase
        end
        S_POP: begin
          fhead_d = lnk_rdata_i;
          state_d = S_INS;
        end
        S_INS: begin
          ent_we_o = 1'b1;
          if (pos_q == '0) begin
            lnk_we_o    = 1'b1;
            lnk_waddr_o = fresh_q;
            lnk_wdata_o = head_q;
            head_d      = fresh_q;
            count_d     = count_q + CW'(1);
            ok_d        = 1'b1;
            state_d     = S_IDLE;
            fin_d       = 1'b1;
          end else begin
            lnk_re_o    = 1'b1;
            lnk_raddr_o = head_q;
            cur_d       = head_q;
            idx_d       = '0;
            tgt_d       = pos_m1[CW-1:0];
            state_d     = S_WALK;
          end
        end
        S_WALK: begin
          if (idx_q == tgt_q) begin
            succ_d  = lnk_rdata_i;
            state_d = S_OP;
          end else begin
            prev_d      = cur_q;
            cur_d       = lnk_rdata_i;
            idx_d       = idx_q + CW'(1);
            lnk_re_o    = 1'b1;
            lnk_raddr_o = lnk_rdata_i;
          end
        end
        S_OP: begin
          state_d = S_OP2;
          unique case (act_q)
            ACT_INSERT: begin
              lnk_we_o    = 1'b1;
              lnk_waddr_o = fresh_q;
              lnk_wdata_o = succ_q;
            end
            ACT_REMOVE: begin
              ent_re_o = 1'b1;
              if (pos_q == '0) begin
                head_d = succ_q;
              end else begin
                lnk_we_o    = 1'b1;
                lnk_waddr_o = prev_q;
                lnk_wdata_o = succ_q;
              end
            end
            default: begin
              ent_re_o = 1'b1;
            end
          endcase
        end
        S_OP2: begin
          ok_d    = 1'b1;
          state_d = S_IDLE;
          fin_d   = 1'b1;
          unique case (act_q)
            ACT_INSERT: begin
              lnk_we_o    = 1'b1;
              lnk_wdata_o = fresh_q;
              count_d     = count_q + CW'(1);
            end
            ACT_REMOVE: begin
              // push the removed node onto the free list
              lnk_we_o    = 1'b1;
              lnk_wdata_o = fhead_q;
              fhead_d     = cur_q;
              count_d     = count_q - CW'(1);
              rdata_d     = ent_rdata_i;
            end
            default: begin
              rdata_d = ent_rdata_i;
            end
          endcase
        end
        S_REV: begin
          lnk_we_o = 1'b1;
          prev_d   = cur_q;
          if (idx_q == count_q - CW'(1)) begin
            head_d  = cur_q;
            state_d = S_IDLE;
            fin_d   = 1'b1;
          end else begin
            cur_d       = lnk_rdata_i;
            idx_d       = idx_q + CW'(1);
            lnk_re_o    = 1'b1;
            lnk_raddr_o = lnk_rdata_i;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
      count_q <= '0;
      hwm_q   <= '0;
      head_q  <= '0;
      fhead_q <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      count_q <= count_d;
      hwm_q   <= hwm_d;
      head_q  <= head_d;
      fhead_q <= fhead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    pos_q   <= pos_d;
    din_q   <= din_d;
    fresh_q <= fresh_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    succ_q  <= succ_d;
    idx_q   <= idx_d;
    tgt_q   <= tgt_d;
    ok_q    <= ok_d;
    rdata_q <= rdata_d;
  end

  assign in_ready_o          = (state_q == S_IDLE) && !fin_q;
  assign res_valid_o         = fin_q;
  assign res_flags_o.success = ok_q;
  assign res_flags_o.empty   = (count_q == '0);
  assign res_data_o          = rdata_q;
  assign res_count_o         = count_q;

endmodule

`default_nettype wire

### design/positional_list_engine_core.sv
// Ordered list of up to CAPACITY values kept as a singly linked list in two
// node memories (values and next links), each with one write and one
// registered read port. One transaction is worked at a time; the link walk
// reads one link per cycle. An insert at position p takes a node and walks
// to entry p-1 unless p is 0; read and remove walk to entry p; reverse walks
// all entries; clear and failed requests finish in decode. Each result is
// then registered in the output register. Removed nodes go on a free list
// threaded through the link memory; a fill mark hands out untouched nodes,
// so no clearing pass is needed after reset. A new transaction is accepted
// while the previous result still waits in the output register.
// depends on ple_pkg, ple_ram and ple_ctrl
`default_nettype none

module positional_list_engine_core #(
  parameter int CAPACITY   = ple_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // position [6:0], data_in [38:7], zero [39]
  input  wire logic [ple_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // action [2:0]
  input  wire logic [ple_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // success [0], data_out [32:1], entry_count [39:33], is_empty [40], zero [47:41]
  output logic      [ple_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  import ple_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [POS_W-1:0]      in_pos;
  logic [IN_DATA_W-1:0]  in_data;
  logic [DATA_WIDTH-1:0] in_data_ext;
  action_e               in_action;

  logic                  res_valid;
  logic                  res_ready;
  res_flags_t            res_flags;
  logic [DATA_WIDTH-1:0] res_data;
  logic [CW-1:0]         res_count;
  logic [IN_DATA_W-1:0]  res_data_out;
  logic [COUNT_OUT_W-1:0] res_count_out;

  logic                  ent_we;
  logic [AW-1:0]         ent_waddr;
  logic [DATA_WIDTH-1:0] ent_wdata;
  logic                  ent_re;
  logic [AW-1:0]         ent_raddr;
  logic [DATA_WIDTH-1:0] ent_rdata;
  logic                  lnk_we;
  logic [AW-1:0]         lnk_waddr;
  logic [AW-1:0]         lnk_wdata;
  logic                  lnk_re;
  logic [AW-1:0]         lnk_raddr;
  logic [AW-1:0]         lnk_rdata;

  logic                  m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0]  m_data_q, m_data_d;

  assign in_pos    = s_axis_tdata[POS_W-1:0];
  assign in_data   = s_axis_tdata[POS_W+IN_DATA_W-1:POS_W];
  assign in_action = action_e'(s_axis_tuser);

  if (DATA_WIDTH > IN_DATA_W) begin : g_in_wide
    assign in_data_ext = {{(DATA_WIDTH-IN_DATA_W){in_data[IN_DATA_W-1]}}, in_data};
  end else begin : g_in_narrow
    assign in_data_ext = in_data[DATA_WIDTH-1:0];
  end

  if (DATA_WIDTH >= IN_DATA_W) begin : g_out_wide
    assign res_data_out = res_data[IN_DATA_W-1:0];
  end else begin : g_out_narrow
    assign res_data_out = {{(IN_DATA_W-DATA_WIDTH){1'b0}}, res_data};
  end

  if (CW >= COUNT_OUT_W) begin : g_cnt_wide
    assign res_count_out = res_count[COUNT_OUT_W-1:0];
  end else begin : g_cnt_narrow
    assign res_count_out = {{(COUNT_OUT_W-CW){1'b0}}, res_count};
  end

  ple_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  ple_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (AW)
  ) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .re_i    (lnk_re),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  ple_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (in_action),
    .position_i  (in_pos),
    .data_i      (in_data_ext),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_flags_o (res_flags),
    .res_data_o  (res_data),
    .res_count_o (res_count),
    .ent_we_o    (ent_we),
    .ent_waddr_o (ent_waddr),
    .ent_wdata_o (ent_wdata),
    .ent_re_o    (ent_re),
    .ent_raddr_o (ent_raddr),
    .ent_rdata_i (ent_rdata),
    .lnk_we_o    (lnk_we),
    .lnk_waddr_o (lnk_waddr),
    .lnk_wdata_o (lnk_wdata),
    .lnk_re_o    (lnk_re),
    .lnk_raddr_o (lnk_raddr),
    .lnk_rdata_i (lnk_rdata)
  );

  // output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_ready) begin
      m_valid_d = res_valid;
      if (res_valid) begin
        m_data_d = {{(M_TDATA_W-IN_DATA_W-COUNT_OUT_W-2){1'b0}},
                    res_flags.empty, res_count_out, res_data_out, res_flags.success};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_count <= CW'(CAPACITY)))
    else $error("entry count above capacity");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_flags.empty == (res_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transaction taken while one is in work");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> res_valid)
    else $error("pending result dropped");

endmodule

`default_nettype wire
